// ===== src/buffalo_escape_time_pixel_macros.svh =====
// ----------------------------------------------------------------------------
// buffalo_escape_time_pixel assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef BUFFALO_ESCAPE_TIME_PIXEL_MACROS_SVH
`define BUFFALO_ESCAPE_TIME_PIXEL_MACROS_SVH

// same-cycle implication
`define BET_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bet assertion failed");

// next-cycle implication
`define BET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bet assertion failed");

`endif

// ===== src/bet_pkg.sv =====
// ----------------------------------------------------------------------------
// bet_pkg
// Types and constants shared by the escape-time pixel blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bet_pkg;

  localparam int FRAME_WIDTH  = 1024;
  localparam int DEF_MAX_ITER = 64;

  localparam int IN_W       = 24;
  localparam int OUT_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP    = 2'd3;

  localparam logic signed [31:0] ORIGIN_RESET = -32'sd536870912;
  localparam logic signed [31:0] STEP_RESET   = 32'sd0;

  // 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  typedef struct packed {
    logic load_in;
    logic load_cprod;
    logic load_c;
    logic load_sq;
    logic load_upd;
    logic load_out;
  } bet_cmd_t;

  typedef struct packed {
    logic at_max;
    logic escape;
    logic out_free;
  } bet_sts_t;

endpackage

// ===== src/bet_ctrl.sv =====
// ----------------------------------------------------------------------------
// bet_ctrl
// Sequencer: point setup, then square / update steps until escape or limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bet_ctrl
  import bet_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bet_sts_t sts,
  output bet_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CPROD = 3'd1;
  localparam logic [2:0] ST_CSUM  = 3'd2;
  localparam logic [2:0] ST_SQ    = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CPROD;
        end
      end
      ST_CPROD: begin
        cmd.load_cprod = 1'b1;
        state_nxt      = ST_CSUM;
      end
      ST_CSUM: begin
        cmd.load_c = 1'b1;
        state_nxt  = ST_SQ;
      end
      ST_SQ: begin
        if (sts.at_max) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.load_sq = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        if (sts.escape) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.load_upd = 1'b1;
          state_nxt    = ST_SQ;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/bet_dp.sv =====
// ----------------------------------------------------------------------------
// bet_dp
// Datapath: config registers, point setup, Buffalo step, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bet_dp
  import bet_pkg::*;
#(
  parameter int MAX_ITER = DEF_MAX_ITER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_W-1:0]       in_tdata,
  input  bet_cmd_t              cmd,
  output bet_sts_t              sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int ITER_W = $clog2(MAX_ITER + 1);

  localparam logic signed [47:0] SAT_HI = 48'sd2147483647;
  localparam logic signed [47:0] SAT_LO = -48'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] origin_real_r, origin_imag_r, column_step_r, row_step_r;

  logic [9:0]          row_r, col_r;
  logic signed [42:0]  prod_re_r, prod_im_r;
  logic [19:0]         index_r;
  logic signed [31:0]  c_re_r, c_im_r, x_r, y_r;
  logic [ITER_W-1:0]   n_r;
  logic [62:0]         xx_r, yy_r, xy_r;

  logic [19:0]         out_index_r;
  logic [31:0]         out_color_r;
  logic [6:0]          out_count_r;
  logic                out_valid_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= ORIGIN_RESET;
      origin_imag_r <= ORIGIN_RESET;
      column_step_r <= STEP_RESET;
      row_step_r    <= STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ORIGIN_REAL: origin_real_r <= cfg_data;
        CFG_ORIGIN_IMAG: origin_imag_r <= cfg_data;
        CFG_COLUMN_STEP: column_step_r <= cfg_data;
        CFG_ROW_STEP:    row_step_r    <= cfg_data;
      endcase
    end
  end

  // magnitudes and products of the current z
  logic [31:0] ax, ay;
  logic [63:0] xx_p, yy_p, xy_p;

  assign ax   = x_r[31] ? (~x_r + 32'd1) : x_r;
  assign ay   = y_r[31] ? (~y_r + 32'd1) : y_r;
  assign xx_p = ax * ax;
  assign yy_p = ay * ay;
  assign xy_p = ax * ay;

  // escape test and next z
  logic [63:0]        mag_sum;
  logic [62:0]        diff;
  logic signed [31:0] x_nxt, y_nxt;
  logic [31:0]        index_full;

  assign mag_sum = {1'b0, xx_r} + {1'b0, yy_r};
  assign diff    = (xx_r >= yy_r) ? (xx_r - yy_r) : (yy_r - xx_r);
  assign x_nxt   = sat32(48'($signed({1'b0, diff[62:28]})) + 48'(c_re_r));
  // (2*xy) >> 28 is xy >> 27
  assign y_nxt   = sat32(48'($signed({1'b0, xy_r[62:27]})) + 48'(c_im_r));

  assign index_full = 32'(col_r) + 32'(FRAME_WIDTH) * 32'(row_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      row_r <= in_tdata[9:0];
      col_r <= in_tdata[19:10];
    end
    if (cmd.load_cprod) begin
      prod_re_r <= $signed({1'b0, col_r}) * column_step_r;
      prod_im_r <= $signed({1'b0, row_r}) * row_step_r;
      index_r   <= index_full[19:0];
    end
    if (cmd.load_c) begin
      c_re_r <= sat32(48'(origin_real_r) + 48'(prod_re_r));
      c_im_r <= sat32(48'(origin_imag_r) + 48'(prod_im_r));
      x_r    <= sat32(48'(origin_real_r) + 48'(prod_re_r));
      y_r    <= sat32(48'(origin_imag_r) + 48'(prod_im_r));
      n_r    <= '0;
    end
    if (cmd.load_sq) begin
      xx_r <= xx_p[62:0];
      yy_r <= yy_p[62:0];
      xy_r <= xy_p[62:0];
    end
    if (cmd.load_upd) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      n_r <= n_r + ITER_W'(1);
    end
  end

  // result word
  logic [31:0] n32;
  logic [35:0] color_shift;
  logic [31:0] color;

  assign n32         = 32'(n_r);
  assign color_shift = 36'hF << n32[4:0];
  assign color       = (n32 >= 32'(MAX_ITER) || n32 >= 32'd32) ? 32'd0 : color_shift[31:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_index_r <= index_r;
      out_color_r <= color;
      out_count_r <= 7'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.at_max   = (n_r == ITER_W'(MAX_ITER));
  assign sts.escape   = (mag_sum > ESCAPE_LIMIT);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_count_r, out_color_r, out_index_r};

endmodule

// ===== src/buffalo_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// buffalo_escape_time_pixel
// One request at a time: in_tready is high only while idle, so a new request
// is taken only after the last pixel's result is loaded into the output
// register. Each iteration is a multiply step and an update step through the
// shared square unit; iterating stops on escape or at MAX_ITER.
// Reset: synchronous, active low; config returns to its defaults, no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffalo_escape_time_pixel
  import bet_pkg::*;
#(
  parameter int MAX_ITER = DEF_MAX_ITER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] pixel_row, [19:10] pixel_column, [23:20] zero
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [19:0] pixel_index, [51:20] color_word, [58:52] iteration_count, [63:59] zero
  output logic [OUT_W-1:0]      out_tdata
);

  bet_cmd_t cmd;
  bet_sts_t sts;

  bet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bet_dp #(
    .MAX_ITER (MAX_ITER)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/bet_chk.sv =====
// ----------------------------------------------------------------------------
// bet_chk
// Port-level checks on the escape-time pixel block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "buffalo_escape_time_pixel_macros.svh"

module bet_chk
  import bet_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  `BET_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one pixel in flight: no request taken right after another
  `BET_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

  // long counts give a zero color
  `BET_ASSERT_IMPL(a_long_count_dark, out_tvalid && out_tdata[58:52] >= 7'd32,
                   out_tdata[51:20] == 32'd0)

  // a lit color matches its count
  `BET_ASSERT_IMPL(a_color_shape, out_tvalid && out_tdata[51:20] != 32'd0,
                   out_tdata[51:20] == (32'h0000_000F << out_tdata[56:52]))

endmodule

bind buffalo_escape_time_pixel bet_chk u_chk (.*);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: buffalo_escape_time_pixel scoreboard
// Sends pixel requests under several window settings, including saturating
// extremes and bounded points. Predicts index, color and count per request
// and checks results in order, with random valid gaps and ready stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bet_pkg::*;

  localparam int  FRAC_BITS     = 28;
  localparam int  SETTLE_CYCLES = 12;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE = 32'h1000_0000;

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
  } pixel_req_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [31:0] color;
    logic [19:0] index;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // window copy kept in step with the block's registers
  logic signed [31:0] view_re = ORIGIN_RESET;
  logic signed [31:0] view_im = ORIGIN_RESET;
  logic signed [31:0] step_col = STEP_RESET;
  logic signed [31:0] step_row = STEP_RESET;

  pixel_req_t pending_px[$];
  pixel_res_t expected_px[$];
  int     mismatches = 0;
  int     send_gap = 0;
  int     stall_left = 0;
  bit     quiet = 1'b0;
  longint cycles = 0;

  buffalo_escape_time_pixel DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_q428(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pixel_res_t render_pixel(pixel_req_t px);
    longint c_re, c_im, x, y;
    longint unsigned ax, ay, xx, yy, xy, diff;
    int n;
    int lin;
    pixel_res_t r;
    c_re = clamp_q428(longint'(view_re) + longint'({54'd0, px.column}) * longint'(step_col));
    c_im = clamp_q428(longint'(view_im) + longint'({54'd0, px.row}) * longint'(step_row));
    x = c_re;
    y = c_im;
    n = 0;
    while (n < DEF_MAX_ITER) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      xx = ax * ax;
      yy = ay * ay;
      xy = ax * ay;
      if (xx + yy > ESCAPE_LIMIT) break;
      diff = (xx >= yy) ? xx - yy : yy - xx;
      x = clamp_q428(longint'(diff >> FRAC_BITS) + c_re);
      y = clamp_q428(longint'((xy << 1) >> FRAC_BITS) + c_im);
      n++;
    end
    lin = int'(px.column) + FRAME_WIDTH * int'(px.row);
    r.index = lin[19:0];
    r.color = (n >= DEF_MAX_ITER || n >= 32) ? 32'd0 : 32'(64'hF << n);
    r.count = n[6:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_px.size() != 0) begin
        in_tdata <= {4'd0, pending_px.pop_front()};
        in_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 16);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    pixel_res_t want;
    pixel_res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_px.push_back(render_pixel(in_tdata[19:0]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[58:0];
        if (expected_px.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_px.pop_front();
          if (got.index !== want.index) begin
            $display("%0t pixel_index: expected %h, actual %h", $time, want.index, got.index);
            mismatches++;
          end
          if (got.color !== want.color) begin
            $display("%0t color_word: expected %h, actual %h", $time, want.color, got.color);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $display("%0t iteration_count: expected %0d, actual %0d", $time, want.count,
                     got.count);
            mismatches++;
          end
          if (out_tdata[63:59] !== 5'd0) begin
            $display("%0t pad bits: expected 00, actual %h", $time, out_tdata[63:59]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_px.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_ORIGIN_REAL: view_re = value;
      CFG_ORIGIN_IMAG: view_im = value;
      CFG_COLUMN_STEP: step_col = value;
      CFG_ROW_STEP:    step_row = value;
      default: ;
    endcase
  endtask

  task automatic set_view(logic [31:0] re, logic [31:0] im, logic [31:0] cs, logic [31:0] rs);
    write_reg(CFG_ORIGIN_REAL, re);
    write_reg(CFG_ORIGIN_IMAG, im);
    write_reg(CFG_COLUMN_STEP, cs);
    write_reg(CFG_ROW_STEP, rs);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_pixel(int row, int column);
    pixel_req_t px;
    px.row = row[9:0];
    px.column = column[9:0];
    @(negedge clk);
    pending_px.push_back(px);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  // sender holds off until every outstanding request has its result
  task automatic settle();
    @(negedge clk);
    while (pending_px.size() != 0 || in_tvalid || expected_px.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] small_step();
    logic [31:0] mag;
    mag = $urandom_range(0, 1 << $urandom_range(4, 20));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset window: every pixel maps to the same point
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    queue_pixel(1023, 0);
    queue_pixel(10'h2AA, 10'h155);
    queue_pixel(10'h155, 10'h2AA);
    settle();

    // full set across the frame: origin -2, step 4/1024
    set_view(-2 * Q_ONE, -2 * Q_ONE, 32'h0010_0000, 32'h0010_0000);
    queue_pixel(512, 512);  // origin point, never escapes
    queue_pixel(512, 0);    // c = -2 sits on the limit forever
    queue_pixel(0, 0);
    queue_pixel(400, 600);
    queue_pixel(700, 300);
    queue_random(250);
    settle();

    // saturating coordinates at both ends
    set_view(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(1, 1);
    settle();
    set_view(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(3, 700);
    settle();

    set_view(32'd0, 32'd0, 32'd0, 32'd0);
    queue_pixel(5, 9);
    queue_pixel(1023, 1023);
    settle();

    // random zoomed windows
    for (int p = 0; p < 8; p++) begin
      set_view($urandom_range(0, 1 << 30) - (1 << 29), $urandom_range(0, 1 << 30) - (1 << 29),
               small_step(), small_step());
      queue_random(90);
      settle();
    end

    set_view($urandom(), $urandom(), $urandom(), $urandom());
    queue_random(30);
    settle();

    // closing stretch without gaps or stalls
    quiet = 1'b1;
    set_view(-2 * Q_ONE, -2 * Q_ONE, 32'h0010_0000, 32'h0010_0000);
    queue_random(100);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
